// File: rtl/alt_pkg.sv
`timescale 1ns / 1ps
package alt_pkg;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned DRAW_W   = 16;
  localparam int unsigned PREFIX_W = 24;
  localparam int unsigned HOST_W   = 8;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned DEPTH    = 256;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CNT_W    = 9;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 24'hC0A801;

  typedef struct packed {
    logic init_start;   // begin free-list fill pass
    logic init_step;    // write one free entry
    logic load;         // capture request word
    logic scan_start;   // begin lease search
    logic scan_step;    // compare one lease
    logic mod_start;    // begin draw modulo free count
    logic mod_step;     // one restoring-division bit
    logic pick_rd;      // read picked free entry
    logic shift_step;   // move one free entry down
    logic commit;       // write lease, bump counts
    logic emit_hit;
    logic emit_new;
    logic emit_empty;
  } ctl_t;

  typedef struct packed {
    logic init_done;
    logic scan_found;
    logic scan_done;
    logic mod_done;
    logic shift_done;
    logic pool_out;     // no free host or lease table full
  } sts_t;
endpackage

// File: rtl/alt_ctrl.sv
`timescale 1ns / 1ps
module alt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  alt_pkg::sts_t sts,
  output alt_pkg::ctl_t ctl
);
  typedef enum logic [9:0] {
    S_RESET = 10'b0000000001,
    S_INIT  = 10'b0000000010,
    S_IDLE  = 10'b0000000100,
    S_SCAN  = 10'b0000001000,
    S_MOD   = 10'b0000010000,
    S_READ  = 10'b0000100000,
    S_WAIT  = 10'b0001000000,
    S_SHIFT = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_SCAN0 = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_RESET;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    busy = 1'b1;
    case (state_r)
      S_RESET: begin
        ctl.init_start = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        ctl.init_step = 1'b1;
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = S_SCAN0;
        end
      end
      S_SCAN0: begin
        ctl.scan_start = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_found) begin
          ctl.emit_hit = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.scan_done) begin
          if (sts.pool_out) begin
            ctl.emit_empty = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ctl.mod_start = 1'b1;
            state_nxt = S_MOD;
          end
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_MOD: begin
        ctl.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_READ;
      end
      S_READ: begin
        ctl.pick_rd = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_SHIFT;
      S_SHIFT: begin
        if (sts.shift_done) state_nxt = S_DONE;
        else ctl.shift_step = 1'b1;
      end
      S_DONE: begin
        ctl.commit = 1'b1;
        ctl.emit_new = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_RESET;
    endcase
  end
endmodule

// File: rtl/alt_dpath.sv
`timescale 1ns / 1ps
module alt_dpath #(
  parameter int unsigned FIRST_HOST = 2,
  parameter int unsigned HOST_LIMIT = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  alt_pkg::ctl_t                   ctl,
  output alt_pkg::sts_t                   sts,
  input  logic [alt_pkg::MAC_W-1:0]       mac_in,
  input  logic [alt_pkg::DRAW_W-1:0]      draw_in,
  input  logic [alt_pkg::PREFIX_W-1:0]    prefix,
  output logic                            out_valid,
  output logic [alt_pkg::IP_W-1:0]        out_ip,
  output logic                            out_hit,
  output logic                            out_empty
);
  localparam int unsigned CNT_W = alt_pkg::CNT_W;
  localparam int unsigned IDX_W = alt_pkg::IDX_W;
  localparam int unsigned HW    = alt_pkg::HOST_W;
  localparam int unsigned DW    = alt_pkg::DRAW_W;
  localparam logic [CNT_W-1:0] FREE_INIT =
    (FIRST_HOST >= HOST_LIMIT) ? '0 : CNT_W'(HOST_LIMIT - FIRST_HOST);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(alt_pkg::DEPTH);

  logic [alt_pkg::MAC_W-1:0] key_mem [alt_pkg::DEPTH];
  logic [HW-1:0]             host_mem [alt_pkg::DEPTH];
  logic [HW-1:0]             free_mem [alt_pkg::DEPTH];

  logic [alt_pkg::MAC_W-1:0] mac_r;
  logic [DW-1:0]             draw_r;
  logic [CNT_W-1:0]          lease_cnt_r, free_cnt_r;
  logic [CNT_W-1:0]          idx_r;        // init/scan/shift pointer
  logic [CNT_W-1:0]          pick_r;
  logic [CNT_W-1:0]          rem_r;        // modulo remainder
  logic [DW-1:0]             quo_r;        // draw bits still to shift in
  logic [4:0]                bit_r;
  logic [alt_pkg::MAC_W-1:0] key_q;
  logic [HW-1:0]             host_q, free_q, pick_host_r;
  logic                      rd_vld_r;     // key_q/host_q hold entry idx_r-1
  logic                      shift_vld_r;

  // one restoring-division step
  logic [CNT_W:0] rem_sh;
  assign rem_sh = {rem_r, quo_r[DW-1]};

  assign sts.init_done  = (idx_r + 1'b1 >= FREE_INIT) || (FREE_INIT == '0);
  assign sts.scan_found = rd_vld_r && (key_q == mac_r);
  assign sts.scan_done  = !rd_vld_r && (idx_r >= lease_cnt_r);
  assign sts.mod_done   = (bit_r == 5'(DW - 1));
  assign sts.pool_out   = (free_cnt_r == '0) || (lease_cnt_r >= DEPTH_C);
  assign sts.shift_done = (idx_r + 1'b1 >= free_cnt_r) && !shift_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.init_step && FREE_INIT != '0)
      free_mem[idx_r[IDX_W-1:0]] <= HW'(FIRST_HOST + 32'(idx_r));
    if (ctl.commit) begin
      key_mem[lease_cnt_r[IDX_W-1:0]]  <= mac_r;
      host_mem[lease_cnt_r[IDX_W-1:0]] <= pick_host_r;
    end
    key_q  <= key_mem[idx_r[IDX_W-1:0]];
    host_q <= host_mem[idx_r[IDX_W-1:0]];
    free_q <= free_mem[(ctl.pick_rd ? pick_r[IDX_W-1:0] : idx_r[IDX_W-1:0] + 1'b1)];
    // shift: free_q holds entry idx_r+1 read last cycle
    if (shift_vld_r) free_mem[idx_r[IDX_W-1:0]] <= free_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_cnt_r <= '0;
      free_cnt_r  <= FREE_INIT;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      shift_vld_r <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= ctl.emit_hit | ctl.emit_new | ctl.emit_empty;
      // entry idx_r read now, compare next cycle
      rd_vld_r  <= ctl.scan_step && !rd_vld_r;
      if (ctl.init_start) idx_r <= '0;
      if (ctl.init_step)  idx_r <= idx_r + 1'b1;
      if (ctl.load) begin
        mac_r  <= mac_in;
        draw_r <= draw_in;
      end
      if (ctl.scan_start) idx_r <= '0;
      if (ctl.scan_step && !rd_vld_r) idx_r <= idx_r + 1'b1;
      if (ctl.mod_start) begin
        rem_r <= '0;
        quo_r <= draw_r;
        bit_r <= '0;
      end
      if (ctl.mod_step) begin
        bit_r <= bit_r + 1'b1;
        quo_r <= quo_r << 1;
        if (rem_sh >= {1'b0, free_cnt_r}) rem_r <= CNT_W'(rem_sh - {1'b0, free_cnt_r});
        else                              rem_r <= rem_sh[CNT_W-1:0];
        if (sts.mod_done) begin
          pick_r <= (rem_sh >= {1'b0, free_cnt_r}) ? CNT_W'(rem_sh - {1'b0, free_cnt_r})
                                                   : rem_sh[CNT_W-1:0];
          idx_r  <= (rem_sh >= {1'b0, free_cnt_r}) ? CNT_W'(rem_sh - {1'b0, free_cnt_r})
                                                   : rem_sh[CNT_W-1:0];
        end
      end
      shift_vld_r <= ctl.shift_step && !shift_vld_r;
      if (shift_vld_r) idx_r <= idx_r + 1'b1;
      if (ctl.commit) begin
        lease_cnt_r <= lease_cnt_r + 1'b1;
        free_cnt_r  <= free_cnt_r - 1'b1;
      end
      if (ctl.emit_hit) begin
        out_ip    <= {prefix, host_q};
        out_hit   <= 1'b1;
        out_empty <= 1'b0;
      end
      if (ctl.emit_new) begin
        out_ip    <= {prefix, pick_host_r};
        out_hit   <= 1'b0;
        out_empty <= 1'b0;
      end
      if (ctl.emit_empty) begin
        out_ip    <= '0;
        out_hit   <= 1'b0;
        out_empty <= 1'b1;
      end
    end
  end

  // picked host: free_q is read on the read command, then copied to pick_host_r
  logic pick_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pick_vld_r <= 1'b0;
    else        pick_vld_r <= ctl.pick_rd;
    if (pick_vld_r) pick_host_r <= free_q;
  end
endmodule

// File: rtl/address_lease_table.sv
`timescale 1ns / 1ps
// address_lease_table: address lease allocator.
// Request channel: present in_mac and in_random_draw with start while busy
// is low; the word is taken at that clock edge and busy rises.
// The block first searches its lease table one entry at a time, each read
// and then compared. A known MAC answers with its stored address and
// out_hit. A new MAC picks free entry random_draw mod free count; the
// modulo runs one bit a cycle in a restoring divider.
// The chosen entry is removed by moving later free entries down one place,
// each read and then written back. One request is in flight at a time.
// Result: out_valid pulses for one cycle with out_ip_address, out_hit and
// out_pool_empty; the receiver cannot stall, so take it in that cycle.
// Reset: rst_n low clears the lease count and resets the free count; afterwards
// a fill pass writes the free list (free count entries, 254 at default) with busy high.
// cfg_we writes the 24-bit subnet prefix; write only while idle.
module address_lease_table #(
  parameter int unsigned FIRST_HOST = 2,
  parameter int unsigned HOST_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] in_mac,
  input  logic [15:0] in_random_draw,
  input  logic        cfg_we,
  input  logic [23:0] cfg_subnet_prefix,
  output logic        out_valid,
  output logic [31:0] out_ip_address,
  output logic        out_hit,
  output logic        out_pool_empty
);
  alt_pkg::ctl_t ctl;
  alt_pkg::sts_t sts;
  logic [alt_pkg::PREFIX_W-1:0] prefix_r;

  // hold the prefix register
  always_ff @(posedge clk) begin
    if (!rst_n)      prefix_r <= alt_pkg::PREFIX_RESET;
    else if (cfg_we) prefix_r <= cfg_subnet_prefix;
  end

  alt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  alt_dpath #(
    .FIRST_HOST (FIRST_HOST),
    .HOST_LIMIT (HOST_LIMIT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .mac_in    (in_mac),
    .draw_in   (in_random_draw),
    .prefix    (prefix_r),
    .out_valid (out_valid),
    .out_ip    (out_ip_address),
    .out_hit   (out_hit),
    .out_empty (out_pool_empty)
  );
endmodule
